### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define RLMS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Check a property on every rising edge, reset included.
`define RLMS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

### hw/rtl/rlms_pkg.sv
package rlms_pkg;

  localparam int unsigned RowsDefault   = 8;
  localparam int unsigned ColsDefault   = 8;
  localparam int unsigned PhasesDefault = 15;

  // Fixed by the field widths.
  localparam int unsigned Planes   = 3;
  localparam int unsigned Colors   = 3;
  localparam int unsigned LineW    = 5;
  localparam int unsigned CoordW   = 3;
  localparam int unsigned ColorW   = 8;
  localparam int unsigned ColBitsW = 8;
  localparam int unsigned FrameW   = 16;
  localparam int unsigned PlaneW   = 2;
  localparam int unsigned LevelW   = 2;

  localparam logic [FrameW-1:0] FrameLengthReset = 16'd3125;
  localparam logic [FrameW-1:0] FrameCountReset  = 16'd1;

  // Opcodes.
  localparam logic OpPixel = 1'b0;
  localparam logic OpTick  = 1'b1;

  // Plane codes.
  localparam logic [PlaneW-1:0] PlaneLow  = 2'd0;
  localparam logic [PlaneW-1:0] PlaneMid  = 2'd1;
  localparam logic [PlaneW-1:0] PlaneHigh = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [ColorW-1:0] pixel_color;
  } in_item_t;

  typedef struct packed {
    logic [LineW-1:0]    line_index;
    logic [ColBitsW-1:0] column_bits;
    logic                sound_bit;
    logic                frame_strobe;
  } out_item_t;

  // Pixel write request to the plane store.
  typedef struct packed {
    logic              en;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
    logic [ColorW-1:0] color;
  } pix_wr_t;

  // Scan position after a tick, with the tick's side outputs.
  typedef struct packed {
    logic [LineW-1:0]  line;
    logic [PlaneW-1:0] plane;
    logic              sound;
    logic              strobe;
  } scan_info_t;

endpackage

### hw/rtl/rlms_plane_store.sv
module rlms_plane_store #(
  parameter int unsigned ROWS = rlms_pkg::RowsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rlms_pkg::pix_wr_t               wr_i,
  input  logic [rlms_pkg::LineW-1:0]      rd_line_i,
  input  logic [rlms_pkg::PlaneW-1:0]     rd_plane_i,
  output logic [rlms_pkg::ColBitsW-1:0]   rd_data_o
);
  import rlms_pkg::*;

  localparam int unsigned YW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // One entry per matrix row y: red, green and blue scan rows, all planes.
  typedef logic [Colors-1:0][Planes-1:0][ColBitsW-1:0] row_set_t;

  row_set_t          store_q [ROWS];
  logic [YW-1:0]     wr_y;
  logic [CoordW-1:0] wr_bit;
  logic [YW-1:0]     rd_y;
  logic [PlaneW-1:0] rd_color;
  row_set_t          rd_set;

  assign wr_y   = wr_i.y[YW-1:0];
  assign wr_bit = ~wr_i.x;  // column bit 0x80 >> x

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        store_q[r] <= '0;
      end
    end else if (wr_i.en) begin
      for (int c = 0; c < Colors; c++) begin
        for (int b = 0; b < Planes; b++) begin
          store_q[wr_y][c][b][wr_bit] <=
            (wr_i.color[LevelW*c +: LevelW] > LevelW'(b));
        end
      end
    end
  end

  // Map a scan line to its color group and matrix row.
  always_comb begin
    priority if (rd_line_i < LineW'(ROWS)) begin
      rd_color = PlaneW'(0);
      rd_y     = YW'(LineW'(ROWS - 1) - rd_line_i);
    end else if (rd_line_i < LineW'(2 * ROWS)) begin
      rd_color = PlaneW'(1);
      rd_y     = YW'(rd_line_i - LineW'(ROWS));
    end else begin
      rd_color = PlaneW'(2);
      rd_y     = YW'(LineW'(3 * ROWS - 1) - rd_line_i);
    end
  end

  assign rd_set    = store_q[rd_y];
  assign rd_data_o = rd_set[rd_color][rd_plane_i];

endmodule

### hw/rtl/rlms_scan_ctrl.sv
module rlms_scan_ctrl #(
  parameter int unsigned ROWS   = rlms_pkg::RowsDefault,
  parameter int unsigned PHASES = rlms_pkg::PhasesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rlms_pkg::FrameW-1:0]   cfg_data_i,
  input  logic                          tick_i,
  output rlms_pkg::scan_info_t          info_o
);
  import rlms_pkg::*;

  localparam int unsigned ScanLines = 3 * ROWS;
  localparam int unsigned PhaseW    = (PHASES > 1) ? $clog2(PHASES) : 1;

  logic [FrameW-1:0] frame_len_q;
  logic [FrameW-1:0] count_q, count_d, count_dec;
  logic [LineW-1:0]  line_q, line_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [7:0]        sound_q;
  logic              strobe;
  logic              wrap;

  assign count_dec = count_q - FrameW'(1);
  assign strobe    = (count_dec == '0);
  assign count_d   = strobe ? frame_len_q : count_dec;

  assign wrap   = (line_q == LineW'(ScanLines - 1));
  assign line_d = wrap ? '0 : line_q + LineW'(1);

  always_comb begin
    phase_d = phase_q;
    if (wrap) begin
      phase_d = (phase_q == PhaseW'(PHASES - 1)) ? '0 : phase_q + PhaseW'(1);
    end
  end

  always_comb begin
    info_o.line   = line_d;
    info_o.sound  = (sound_q == '0);
    info_o.strobe = strobe;
    priority if ({1'b0, phase_d} >= (PhaseW + 1)'(4)) begin
      info_o.plane = PlaneHigh;
    end else if (phase_d != '0) begin
      info_o.plane = PlaneMid;
    end else begin
      info_o.plane = PlaneLow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= FrameLengthReset;
    end else if (cfg_we_i) begin
      frame_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= FrameCountReset;
      line_q  <= '0;
      phase_q <= '0;
      sound_q <= '0;
    end else if (tick_i) begin
      count_q <= count_d;
      line_q  <= line_d;
      phase_q <= phase_d;
      sound_q <= sound_q + 8'd1;
    end
  end

endmodule

### hw/rtl/rgb_led_matrix_scan_pwm_core.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_item_t)
// out     | output    | out_valid_o / out_ready_i | out_data_o (out_item_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (frame_length)
//
// One item per cycle while the output is not stalled: an item waits in the
// input register, where a pixel write updates the plane store and a tick
// advances the scan counters and reads one plane byte into the output
// register, which drives out_valid_o. Reset clears the line, phase and sound
// counters and the whole plane store at once and sets the frame length and
// frame countdown to their reset values. A stalled output holds a tick in the
// input register; pixel writes still drain past a full output register.
`include "assert_macros.svh"

module rgb_led_matrix_scan_pwm_core #(
  parameter int unsigned ROWS   = rlms_pkg::RowsDefault,
  parameter int unsigned COLS   = rlms_pkg::ColsDefault,
  parameter int unsigned PHASES = rlms_pkg::PhasesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rlms_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rlms_pkg::out_item_t         out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rlms_pkg::FrameW-1:0] cfg_data_i
);
  import rlms_pkg::*;

  logic         s1_valid_q;
  in_item_t     s1_item_q;
  logic         out_valid_q;
  out_item_t    out_q;
  logic         s1_is_tick;
  logic         s1_go;
  logic         out_free;
  logic         tick_fire;
  logic         pix_in_range;
  pix_wr_t      pix_wr;
  scan_info_t   scan_info;
  logic [ColBitsW-1:0] col_bits;

  assign cfg_ready_o = 1'b1;

  assign s1_is_tick = (s1_item_q.opcode == OpTick);
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!s1_is_tick || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign tick_fire  = s1_go && s1_is_tick;

  assign pix_in_range = ({1'b0, s1_item_q.pixel_x} < (CoordW + 1)'(COLS)) &&
                        ({1'b0, s1_item_q.pixel_y} < (CoordW + 1)'(ROWS));

  assign pix_wr.en    = s1_go && !s1_is_tick && pix_in_range;
  assign pix_wr.x     = s1_item_q.pixel_x;
  assign pix_wr.y     = s1_item_q.pixel_y;
  assign pix_wr.color = s1_item_q.pixel_color;

  rlms_scan_ctrl #(
    .ROWS   (ROWS),
    .PHASES (PHASES)
  ) u_scan_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .tick_i     (tick_fire),
    .info_o     (scan_info)
  );

  rlms_plane_store #(
    .ROWS (ROWS)
  ) u_plane_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (pix_wr),
    .rd_line_i  (scan_info.line),
    .rd_plane_i (scan_info.plane),
    .rd_data_o  (col_bits)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      out_q.line_index   <= scan_info.line;
      out_q.column_bits  <= col_bits;
      out_q.sound_bit    <= scan_info.sound;
      out_q.frame_strobe <= scan_info.strobe;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RLMS_ASSERT(a_ready_low_only_on_stall, clk_i, rst_ni,
    !in_ready_o |-> (s1_valid_q && s1_is_tick && out_valid_q && !out_ready_i))
  `RLMS_ASSERT(a_result_from_tick, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_is_tick))
  `RLMS_ASSERT(a_pixel_gives_no_result, clk_i, rst_ni,
    (s1_valid_q && !s1_is_tick && !out_valid_q) |=> !out_valid_q)
  `RLMS_ASSERT(a_line_in_range, clk_i, rst_ni,
    out_valid_q |-> (out_q.line_index < LineW'(3 * ROWS)))
  `RLMS_ASSERT_ALWAYS(a_no_store_write_in_reset, clk_i,
    !rst_ni |-> !pix_wr.en || s1_valid_q)

endmodule

### bench/rgb_led_matrix_scan_pwm_checker.sv
`timescale 1ns / 1ps

module rgb_led_matrix_scan_pwm_checker
  import rlms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [FrameW-1:0]   cfg_data_i,
  output int                  pending_o,
  output int                  fail_count_o
);

  localparam int unsigned ScanLines  = 3 * RowsDefault;
  localparam int unsigned StoreDepth = ScanLines * Planes;
  localparam int unsigned MaxReports = 10;

  logic [ColBitsW-1:0] plane_bytes [StoreDepth];
  logic [LineW-1:0]    line_q;
  logic [3:0]          phase_q;
  logic [7:0]          sound_q;
  logic [FrameW-1:0]   countdown_q;
  logic [FrameW-1:0]   frame_len_q;
  out_item_t           expected_lines [$];
  int                  fails;

  function automatic void clear_scan_state();
    foreach (plane_bytes[i]) plane_bytes[i] = '0;
    line_q      = '0;
    phase_q     = '0;
    sound_q     = '0;
    countdown_q = FrameCountReset;
    frame_len_q = FrameLengthReset;
  endfunction

  // Set or clear one column bit in all three planes of the pixel's three rows.
  function automatic void paint_pixel(in_item_t it);
    logic [ColBitsW-1:0] mask;
    int unsigned         row [Colors];
    logic [LevelW-1:0]   level [Colors];
    int unsigned         idx;
    mask     = 8'h80 >> it.pixel_x;
    row[0]   = RowsDefault - 1 - it.pixel_y;
    row[1]   = RowsDefault + it.pixel_y;
    row[2]   = ScanLines - 1 - it.pixel_y;
    level[0] = it.pixel_color[1:0];
    level[1] = it.pixel_color[3:2];
    level[2] = it.pixel_color[5:4];
    for (int unsigned c = 0; c < Colors; c++) begin
      for (int unsigned b = 0; b < Planes; b++) begin
        idx = row[c] * Planes + b;
        if (level[c] > b) begin
          plane_bytes[idx] = plane_bytes[idx] | mask;
        end else begin
          plane_bytes[idx] = plane_bytes[idx] & ~mask;
        end
      end
    end
  endfunction

  // One scan tick: frame countdown, line and phase advance, plane read, sound.
  function automatic out_item_t advance_scan();
    out_item_t         res;
    logic [PlaneW-1:0] plane;
    res         = '0;
    countdown_q = countdown_q - 1'b1;
    if (countdown_q == '0) begin
      countdown_q      = frame_len_q;
      res.frame_strobe = 1'b1;
    end
    if (line_q == ScanLines - 1) begin
      line_q  = '0;
      phase_q = (phase_q == PhasesDefault - 1) ? '0 : phase_q + 1'b1;
    end else begin
      line_q = line_q + 1'b1;
    end
    if (phase_q >= 4) begin
      plane = PlaneHigh;
    end else if (phase_q >= 1) begin
      plane = PlaneMid;
    end else begin
      plane = PlaneLow;
    end
    res.line_index  = line_q;
    res.column_bits = plane_bytes[line_q * Planes + plane];
    res.sound_bit   = (sound_q == '0);
    sound_q         = sound_q + 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      clear_scan_state();
      expected_lines.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_lines.size() == 0) begin
          fails++;
          if (fails <= MaxReports) begin
            $display("%0t: result with nothing expected: line %0d cols %02h snd %0b frm %0b",
                     $time, out_data_i.line_index, out_data_i.column_bits,
                     out_data_i.sound_bit, out_data_i.frame_strobe);
          end
        end else begin
          want = expected_lines.pop_front();
          if (want.line_index !== out_data_i.line_index ||
              want.column_bits !== out_data_i.column_bits ||
              want.sound_bit !== out_data_i.sound_bit ||
              want.frame_strobe !== out_data_i.frame_strobe) begin
            fails++;
            if (fails <= MaxReports) begin
              $display("%0t: mismatch exp line %0d cols %02h snd %0b frm %0b",
                       $time, want.line_index, want.column_bits,
                       want.sound_bit, want.frame_strobe);
              $display("%0t:          got line %0d cols %02h snd %0b frm %0b",
                       $time, out_data_i.line_index, out_data_i.column_bits,
                       out_data_i.sound_bit, out_data_i.frame_strobe);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        frame_len_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.opcode == OpTick) begin
          expected_lines.push_back(advance_scan());
        end else begin
          paint_pixel(in_data_i);
        end
      end
      pending_o    <= expected_lines.size();
      fail_count_o <= fails;
    end
  end

endmodule

### bench/rgb_led_matrix_scan_pwm_core_test.sv
`timescale 1ns / 1ps

module rgb_led_matrix_scan_pwm_core_test;
  import rlms_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned PhaseItems    = 320;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  in_item_t          in_data   = '0;
  logic              out_ready = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [FrameW-1:0] cfg_data  = '0;
  logic              in_ready;
  logic              out_valid;
  out_item_t         out_data;
  logic              cfg_ready;
  int                pending;
  int                fail_count;
  int                idle_cycles = 0;
  int                send_calm   = 0;
  int                recv_calm   = 0;

  rgb_led_matrix_scan_pwm_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  rgb_led_matrix_scan_pwm_checker scan_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("** rgb_led_matrix_scan_pwm_core: FAILED **");
      $finish;
    end
  end

  // Mostly random waits, with occasional runs of back-to-back transfers.
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic in_item_t pixel_item(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                          logic [ColorW-1:0] color);
    in_item_t it;
    it             = '0;
    it.opcode      = OpPixel;
    it.pixel_x     = x;
    it.pixel_y     = y;
    it.pixel_color = color;
    return it;
  endfunction

  // Ticks carry random pixel fields too; the block must ignore them.
  function automatic in_item_t random_item(bit tick_only);
    in_item_t it;
    it = pixel_item(CoordW'($urandom_range(0, 7)), CoordW'($urandom_range(0, 7)),
                    ColorW'($urandom_range(0, 255)));
    if (tick_only || $urandom_range(0, 9) < 6) begin
      it.opcode = OpTick;
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit no_gap);
    int gap;
    gap = no_gap ? 0 : draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Hold the sender until every tick has come out and the pipe is empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_frame_length(logic [FrameW-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0) begin
        wait_drained();
      end
      send_item(random_item(1'b0), 1'b0);
    end
  endtask

  initial begin
    in_item_t tick;
    tick        = '0;
    tick.opcode = OpTick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short frame first; the first tick runs out the reset countdown and reloads it.
    write_frame_length(16'd2);

    // Directed: empty store, full and cleared pixels, each level, ignored color bits.
    send_item(tick, 1'b0);
    send_item(pixel_item(3'd0, 3'd0, 8'hFF), 1'b0);
    send_item(pixel_item(3'd7, 3'd7, 8'h3F), 1'b0);
    send_item(pixel_item(3'd0, 3'd7, 8'h15), 1'b0);
    send_item(pixel_item(3'd3, 3'd4, 8'h2A), 1'b0);
    send_item(pixel_item(3'd5, 3'd2, 8'hC0), 1'b0);
    send_item(pixel_item(3'd7, 3'd0, 8'hE4), 1'b0);
    send_item(pixel_item(3'd4, 3'd1, 8'h1B), 1'b0);
    send_item(pixel_item(3'd0, 3'd0, 8'h00), 1'b0);
    send_item(pixel_item(3'd7, 3'd7, 8'h00), 1'b0);
    repeat (14) send_item(tick, 1'b0);
    wait_drained();

    run_random_phase(PhaseItems);

    wait_drained();
    write_frame_length(16'd1);
    run_random_phase(PhaseItems);

    wait_drained();
    write_frame_length(FrameW'($urandom_range(3, 40)));
    run_random_phase(PhaseItems);

    // Zero length: the countdown wraps after the reload, so no strobe follows.
    wait_drained();
    write_frame_length(16'd0);
    run_random_phase(PhaseItems);

    wait_drained();
    write_frame_length(16'hFFFF);
    run_random_phase(PhaseItems);

    wait_drained();
    if (fail_count == 0) begin
      $display("** rgb_led_matrix_scan_pwm_core: PASSED **");
    end else begin
      $display("** rgb_led_matrix_scan_pwm_core: FAILED **");
    end
    $finish;
  end

  initial begin
    int stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = draw_gap(recv_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

endmodule
